### hdl/raycast_wall_texel_address_unit_macros.svh
// Assertion macros for the raycast wall texel address unit.
// Used by the port checker; no other dependencies.
`ifndef RAYCAST_WALL_TEXEL_ADDRESS_UNIT_MACROS_SVH
`define RAYCAST_WALL_TEXEL_ADDRESS_UNIT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define RWTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, but also checked while reset is applied
`define RWTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/rwta_pkg.sv
// Shared types, constants and helpers for the wall texel address unit.
// No dependencies.
`timescale 1ns / 1ps

package rwta_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCREEN_HEIGHT  = 2'd0,
    REG_TEXTURE_WIDTH  = 2'd1,
    REG_TEXTURE_HEIGHT = 2'd2
  } cfg_reg_e;

  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [10:0] TEX_SIZE_RST      = 11'd64;
  localparam logic [10:0] TEX_SIZE_MAX      = 11'd1024;

  // Texture row divider: 11 quotient bits, 39-bit numerator, 28-bit divisor
  localparam int unsigned DIV_BITS = 11;
  localparam int unsigned NUM_W    = 39;
  localparam int unsigned DEN_W    = 28;
  localparam int unsigned NUM_STG  = DIV_BITS + 2;

  // Input item
  typedef struct packed {
    logic [11:0]        column;
    logic [11:0]        row;
    logic               wall_side;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic signed [19:0] dir_x;
    logic signed [19:0] dir_y;
    logic [31:0]        perp_dist;
    logic [19:0]        line_height;
    logic [11:0]        wall_top;
    logic [11:0]        wall_bottom;
    logic [3:0]         tex_index;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [11:0] out_column;
    logic [11:0] out_row;
    logic [3:0]  out_tex_index;
    logic [9:0]  tex_x;
    logic [9:0]  tex_y;
    logic        drawn;
  } result_t;

  // Classified item, front to back
  typedef struct packed {
    logic [11:0]        col;
    logic [11:0]        row;
    logic [3:0]         tidx;
    logic               mirror;
    logic               drawn;
    logic               neg;
    logic [15:0]        pos16;
    logic [31:0]        perp;
    logic signed [19:0] dir;
    logic [27:0]        dmag;
    logic [19:0]        height;
  } work_t;

  // One stage of the back pipeline
  typedef struct packed {
    logic [11:0]        col;
    logic [11:0]        row;
    logic [3:0]         tidx;
    logic               mirror;
    logic               drawn;
    logic               neg;
    logic [15:0]        pos16;
    logic [15:0]        prod16;
    logic [9:0]         tx;
    logic [NUM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [DIV_BITS-1:0] quo;
    logic               sat;
  } stage_t;

  // Texture size saturates into [1, 1024]
  function automatic logic [10:0] clamp_tex(logic [10:0] v);
    logic [10:0] r;
    if (v == 11'd0) begin
      r = 11'd1;
    end else if (v > TEX_SIZE_MAX) begin
      r = TEX_SIZE_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/rwta_front.sv
// Front classifier: picks the hit axis, mirror and drawn flags, row offset.
// Depends on rwta_pkg.
`timescale 1ns / 1ps

module rwta_front import rwta_pkg::*; (
  input  in_item_t    item_i,
  input  logic [11:0] screen_height_i,
  output work_t       work_o
);

  logic signed [29:0] d;
  logic               side;

  assign side = item_i.wall_side;

  // d = row*256 - H*128 + height*128
  assign d = $signed({10'd0, item_i.row, 8'd0})
           - $signed({11'd0, screen_height_i, 7'd0})
           + $signed({3'd0, item_i.line_height, 7'd0});

  always_comb begin
    work_o.col    = item_i.column;
    work_o.row    = item_i.row;
    work_o.tidx   = item_i.tex_index;
    // x-side facing +x or y-side facing -y reads the texture mirrored
    work_o.mirror = (!side && !item_i.dir_x[19] && (item_i.dir_x != 20'sd0))
                  || (side && item_i.dir_y[19]);
    work_o.drawn  = (item_i.row >= item_i.wall_top) && (item_i.row < item_i.wall_bottom)
                  && (item_i.line_height != 20'd0);
    work_o.neg    = d[29];
    work_o.pos16  = side ? item_i.pos_x[15:0] : item_i.pos_y[15:0];
    work_o.perp   = item_i.perp_dist;
    work_o.dir    = side ? item_i.dir_x : item_i.dir_y;
    work_o.dmag   = d[27:0];
    work_o.height = item_i.line_height;
  end

endmodule

### hdl/rwta_fifo.sv
// Two-entry queue between the front classifier and the back pipeline.
// Depends on rwta_pkg.
`timescale 1ns / 1ps

module rwta_fifo import rwta_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output work_t data_o,
  output logic  empty_o
);

  work_t       mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= !wptr_q;
      if (do_pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

### hdl/rwta_back.sv
// Back pipeline: hit fraction multiply, texture column, restoring divide for
// the texture row, then a result register. Depends on rwta_pkg.
`timescale 1ns / 1ps

module rwta_back import rwta_pkg::*; #(
  parameter int unsigned TEXTURE_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  work_t       head_i,
  input  logic        head_empty_i,
  output logic        head_pop_o,
  input  logic [10:0] texw_i,
  input  logic [10:0] texh_i,
  input  logic        pop,
  output logic        empty,
  output result_t     result_o
);

  stage_t      st_q [NUM_STG];
  stage_t      st_d [NUM_STG];
  logic        v_q  [NUM_STG];
  logic        en;
  logic        out_v_q;
  result_t     out_q, out_d;
  logic [31:0] dir_ext;
  logic [31:0] prod;
  logic [15:0] frac;
  logic [26:0] txp;
  logic [10:0] texh_m1;
  logic [10:0] q_sat;
  logic [10:0] tx_m;
  logic [3:0]  tidx_map [16];

  // Whole pipeline moves when the result register is free or drained
  assign en         = !out_v_q || pop;
  assign head_pop_o = en && !head_empty_i;
  assign empty      = !out_v_q;
  assign result_o   = out_q;

  // Stage 0: low half of perp * dir, and numerator of the row divide
  assign dir_ext = {{12{head_i.dir[19]}}, head_i.dir};
  assign prod    = head_i.perp * dir_ext;

  always_comb begin
    st_d[0]        = '0;
    st_d[0].col    = head_i.col;
    st_d[0].row    = head_i.row;
    st_d[0].tidx   = head_i.tidx;
    st_d[0].mirror = head_i.mirror;
    st_d[0].drawn  = head_i.drawn;
    st_d[0].neg    = head_i.neg;
    st_d[0].pos16  = head_i.pos16;
    st_d[0].prod16 = prod[31:16];
    st_d[0].rem    = {11'd0, head_i.dmag} * {28'd0, texh_i};
    st_d[0].den    = {head_i.height, 8'd0};
  end

  // Stage 1: fraction, texture column, quotient overflow
  assign frac = st_q[0].pos16 + st_q[0].prod16;
  assign txp  = {11'd0, frac} * {16'd0, texw_i};

  always_comb begin
    st_d[1]     = st_q[0];
    st_d[1].tx  = txp[25:16];
    st_d[1].sat = st_q[0].rem >= {st_q[0].den, 11'd0};
    st_d[1].quo = '0;
  end

  // Stages 2..: one restoring quotient bit each, most significant first
  for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
    localparam int unsigned B = DIV_BITS - 1 - g;
    logic [NUM_W-1:0] shd;
    assign shd = {{(NUM_W-DEN_W){1'b0}}, st_q[g+1].den} << B;
    always_comb begin
      st_d[g+2] = st_q[g+1];
      if (st_q[g+1].rem >= shd) begin
        st_d[g+2].rem    = st_q[g+1].rem - shd;
        st_d[g+2].quo[B] = 1'b1;
      end
    end
  end

  // Texture index wrap table
  for (genvar g = 0; g < 16; g++) begin : g_tidx
    assign tidx_map[g] = 4'(g % TEXTURE_COUNT);
  end

  // Final: mirror the column, clamp the row
  assign texh_m1 = texh_i - 11'd1;
  assign tx_m    = texw_i - {1'b0, st_q[NUM_STG-1].tx} - 11'd1;

  always_comb begin
    if (st_q[NUM_STG-1].sat || (st_q[NUM_STG-1].quo > texh_m1)) begin
      q_sat = texh_m1;
    end else begin
      q_sat = st_q[NUM_STG-1].quo;
    end
    out_d.out_column    = st_q[NUM_STG-1].col;
    out_d.out_row       = st_q[NUM_STG-1].row;
    out_d.out_tex_index = tidx_map[st_q[NUM_STG-1].tidx];
    out_d.tex_x         = st_q[NUM_STG-1].mirror ? tx_m[9:0] : st_q[NUM_STG-1].tx;
    out_d.tex_y         = (st_q[NUM_STG-1].drawn && !st_q[NUM_STG-1].neg) ? q_sat[9:0]
                                                                         : 10'd0;
    out_d.drawn         = st_q[NUM_STG-1].drawn;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STG; i++) v_q[i] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= !head_empty_i;
      for (int i = 1; i < NUM_STG; i++) v_q[i] <= v_q[i-1];
      out_v_q <= v_q[NUM_STG-1];
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_STG; i++) st_q[i] <= st_d[i];
      out_q <= out_d;
    end
  end

endmodule

### hdl/raycast_wall_texel_address_unit.sv
// Raycast wall texel address unit, top level.
// Depends on rwta_pkg, rwta_front, rwta_fifo, rwta_back.
//
// Usage:
//   Input queue side: drive in_item_i and raise push; the item is taken at a
//   clock edge with push high and full low. Result side: while empty is low,
//   result_o holds the oldest result; pop high at an edge takes it.
//   Configuration: cfg_index_i selects screen height (0), texture width (1)
//   or texture height (2); a write lands when cfg_valid_i and cfg_ready_o are
//   high. cfg_ready_o is always high. Write only while the unit is idle.
// Timing:
//   One item per clock sustained while results are popped. An item taken at an
//   edge moves from the input queue through one multiply stage, one column
//   stage, eleven divide stages (one texture row quotient bit each) and the
//   result register.
// Reset and stalls:
//   Reset empties the queue and pipeline and loads H=480, texture 64x64.
//   While a result waits unpopped the pipeline holds; the two-entry input
//   queue then fills and full rises.
`timescale 1ns / 1ps

module raycast_wall_texel_address_unit import rwta_pkg::*; #(
  parameter int unsigned TEXTURE_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  input  logic        pop,
  output logic        empty,
  output result_t     result_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  logic [11:0] screen_height_q;
  logic [10:0] texture_width_q, texture_height_q;
  logic [10:0] texw, texh;
  work_t       work, head;
  logic        head_empty, head_pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q  <= SCREEN_HEIGHT_RST;
      texture_width_q  <= TEX_SIZE_RST;
      texture_height_q <= TEX_SIZE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SCREEN_HEIGHT:  screen_height_q  <= cfg_data_i;
        REG_TEXTURE_WIDTH:  texture_width_q  <= cfg_data_i[10:0];
        REG_TEXTURE_HEIGHT: texture_height_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign texw = clamp_tex(texture_width_q);
  assign texh = clamp_tex(texture_height_q);

  rwta_front u_front (
    .item_i          (in_item_i),
    .screen_height_i (screen_height_q),
    .work_o          (work)
  );

  rwta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (work),
    .full_o  (full),
    .pop_i   (head_pop),
    .data_o  (head),
    .empty_o (head_empty)
  );

  rwta_back #(
    .TEXTURE_COUNT (TEXTURE_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .texw_i       (texw),
    .texh_i       (texh),
    .pop          (pop),
    .empty        (empty),
    .result_o     (result_o)
  );

endmodule

### hdl/rwta_checker.sv
// Port-level checker for the wall texel address unit, bound to the top level.
// Depends on rwta_pkg and the macro header.
`timescale 1ns / 1ps
`include "raycast_wall_texel_address_unit_macros.svh"

module rwta_checker import rwta_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input in_item_t    in_item_i,
  input logic        pop,
  input logic        empty,
  input result_t     result_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [11:0] cfg_data_i
);

  // A waiting result that is not taken stays, unchanged
  `RWTA_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(result_o)), "result dropped or changed while stalled")

  // Rows outside the slice never carry a texture row
  `RWTA_ASSERT(a_undrawn, (!empty && !result_o.drawn) |-> (result_o.tex_y == 10'd0), "tex_y nonzero on undrawn row")

  // The input queue only fills after items were pushed
  `RWTA_ASSERT(a_full, $rose(full) |-> $past(push), "full rose without a push")

endmodule

bind raycast_wall_texel_address_unit rwta_checker u_rwta_checker (.*);

### verif/raycast_wall_texel_address_unit_test.sv
// Self-checking bench for the raycast wall texel address unit.
// Depends on rwta_pkg and raycast_wall_texel_address_unit.
`timescale 1ns / 1ps

module raycast_wall_texel_address_unit_test;
  import rwta_pkg::*;

  // Computes expected texel addresses and holds them in arrival order
  class texel_scoreboard;
    logic [11:0] scr_h;
    logic [10:0] tex_w;
    logic [10:0] tex_h;
    result_t     pending[$];
    int          errors;
    int          checked;

    function void reset_regs();
      scr_h = SCREEN_HEIGHT_RST;
      tex_w = TEX_SIZE_RST;
      tex_h = TEX_SIZE_RST;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void note_input(in_item_t it);
      longint tw, th, dir, d, ty, tx;
      logic [63:0] pos, prod, sum;
      logic [15:0] frac;
      result_t r;
      bit on;
      tw = (tex_w == 0) ? 1 : (tex_w > 1024) ? 1024 : tex_w;
      th = (tex_h == 0) ? 1 : (tex_h > 1024) ? 1024 : tex_h;
      pos = it.wall_side ? {32'd0, it.pos_x} : {32'd0, it.pos_y};
      dir = it.wall_side ? longint'(it.dir_x) : longint'(it.dir_y);
      prod = longint'({32'd0, it.perp_dist}) * dir;
      sum = (pos << 16) + prod;
      frac = sum[31:16];
      tx = (longint'({48'd0, frac}) * tw) >>> 16;
      if ((!it.wall_side && it.dir_x > 0) || (it.wall_side && it.dir_y < 0))
        tx = tw - tx - 1;
      on = it.row >= it.wall_top && it.row < it.wall_bottom && it.line_height != 0;
      ty = 0;
      if (on) begin
        d = longint'(it.row) * 256 - longint'(scr_h) * 128
            + longint'(it.line_height) * 128;
        ty = ((d * th) / longint'(it.line_height)) / 256;
        if (ty < 0) ty = 0;
        if (ty > th - 1) ty = th - 1;
      end
      r.out_column    = it.column;
      r.out_row       = it.row;
      r.out_tex_index = it.tex_index;
      r.tex_x         = tx[9:0];
      r.tex_y         = ty[9:0];
      r.drawn         = on;
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.out_column !== e.out_column) begin
        $error("out_column exp %0d got %0d", e.out_column, got.out_column); errors++;
      end
      if (got.out_row !== e.out_row) begin
        $error("out_row exp %0d got %0d", e.out_row, got.out_row); errors++;
      end
      if (got.out_tex_index !== e.out_tex_index) begin
        $error("out_tex_index exp %0d got %0d", e.out_tex_index, got.out_tex_index);
        errors++;
      end
      if (got.tex_x !== e.tex_x) begin
        $error("tex_x exp %0d got %0d", e.tex_x, got.tex_x); errors++;
      end
      if (got.tex_y !== e.tex_y) begin
        $error("tex_y exp %0d got %0d", e.tex_y, got.tex_y); errors++;
      end
      if (got.drawn !== e.drawn) begin
        $error("drawn exp %0d got %0d", e.drawn, got.drawn); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item_i = '0;
  logic        pop = 1'b0;
  logic        empty;
  result_t     result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  texel_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  longint      cycles = 0;
  int          pushed = 0;

  localparam longint CYCLE_LIMIT = 400000;

  raycast_wall_texel_address_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: check accepted results, stall pop at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(result_o);
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Register write while idle; valid drops for a cycle after each write
  task automatic write_reg(cfg_reg_e idx, logic [11:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SCREEN_HEIGHT:  sb.scr_h = val;
      REG_TEXTURE_WIDTH:  sb.tex_w = val[10:0];
      default:            sb.tex_h = val[10:0];
    endcase
    @(posedge clk_i);
  endtask

  // Offer one item; return once accepted with push still high
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_input(it);
    pushed++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it.column      = 12'($urandom);
    it.wall_side   = 1'($urandom);
    it.pos_x       = $urandom;
    it.pos_y       = $urandom;
    it.dir_x       = 20'($urandom);
    it.dir_y       = 20'($urandom);
    it.perp_dist   = $urandom;
    it.tex_index   = 4'($urandom);
    if ($urandom_range(3) != 0) begin
      // plausible slice: row mostly inside it
      it.line_height = 20'($urandom_range(4095, 1));
      it.wall_top    = 12'($urandom_range(2047));
      it.wall_bottom = 12'(it.wall_top + $urandom_range(2047, 1));
      it.row         = 12'(it.wall_top + $urandom_range(it.wall_bottom - it.wall_top));
    end else begin
      it.line_height = ($urandom_range(7) == 0) ? 20'd0 : 20'($urandom);
      it.wall_top    = 12'($urandom);
      it.wall_bottom = 12'($urandom);
      it.row         = 12'($urandom);
    end
    return it;
  endfunction

  task automatic directed();
    in_item_t it;
    it = '0;
    it.line_height = 20'd100; it.wall_bottom = 12'hFFF;
    send_item(it);
    it = '1;
    send_item(it);
    // negative hit coordinate
    it = rand_item(); it.pos_y = 32'd0; it.dir_y = -20'sd65536; it.wall_side = 1'b0;
    send_item(it);
    it.wall_side = 1'b1; it.pos_x = 32'd0; it.dir_x = 20'sh80000; it.dir_y = 20'sh7FFFF;
    send_item(it);
    // mirroring in both sides
    it = rand_item(); it.wall_side = 1'b0; it.dir_x = 20'sd5; send_item(it);
    it.wall_side = 1'b1; it.dir_y = -20'sd5; send_item(it);
    // not drawn: zero height, row above, row at bottom
    it = rand_item(); it.line_height = 20'd0; send_item(it);
    it = rand_item(); it.wall_top = 12'd100; it.row = 12'd99; send_item(it);
    it.wall_bottom = 12'd200; it.row = 12'd200; it.line_height = 20'd5; send_item(it);
    // texture row saturation both ways
    it.row = 12'd100; it.line_height = 20'd1; send_item(it);
    it.row = 12'd199; send_item(it);
    it.line_height = 20'hFFFFF; send_item(it);
    it.row = 12'hFFF; it.wall_bottom = 12'hFFF; it.wall_top = 12'd0; send_item(it);
  endtask

  int phase, k;
  initial begin
    sb = new();
    sb.reset_regs();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (phase = 0; phase < 8; phase++) begin
      drain();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case (phase)
        0: begin write_reg(REG_SCREEN_HEIGHT, 12'd1);
                 write_reg(REG_TEXTURE_WIDTH, 12'd1);
                 write_reg(REG_TEXTURE_HEIGHT, 12'd1); end
        1: begin write_reg(REG_SCREEN_HEIGHT, 12'd4095);
                 write_reg(REG_TEXTURE_WIDTH, 12'd1024);
                 write_reg(REG_TEXTURE_HEIGHT, 12'd1024); end
        2: begin write_reg(REG_TEXTURE_WIDTH, 12'd0);
                 write_reg(REG_TEXTURE_HEIGHT, 12'h7FF); end
        3: begin write_reg(REG_TEXTURE_WIDTH, 12'hFFF);
                 write_reg(REG_TEXTURE_HEIGHT, 12'd0);
                 write_reg(REG_SCREEN_HEIGHT, 12'd0); end
        default: begin write_reg(REG_SCREEN_HEIGHT, 12'($urandom));
                 write_reg(REG_TEXTURE_WIDTH, 12'($urandom_range(1024, 1)));
                 write_reg(REG_TEXTURE_HEIGHT, 12'($urandom_range(1024, 1))); end
      endcase
      for (k = 0; k < 112; k++) send_item(rand_item());
    end
    drain();
    $display("Pushed %0d items over eight register settings and four idle mixes;",
             pushed);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
